// ----- rtl/core/msws_pkg.sv -----
// Shared constants and types for the maximum square window sum block.
// No dependencies; compile first.
`timescale 1ns / 1ps

package msws_pkg;

  localparam int DEF_MAX_SIDE    = 1024;
  localparam int DEF_MAX_WINDOW  = 32;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int SIDE_W   = 11;
  localparam int WINDOW_W = 6;
  localparam int BEST_W   = 36;

  // APB register map: two 32-bit registers, byte addresses 0 and 4
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [SIDE_W-1:0]   SIDE_RST   = 11'd1024;
  localparam logic [WINDOW_W-1:0] WINDOW_RST = 6'd1;

  localparam logic signed [BEST_W-1:0] BEST_MIN = {1'b1, {(BEST_W-1){1'b0}}};

  // result queue depth; covers the items still in the pipe at full rate
  localparam int OUT_DEPTH = 8;
  localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

  typedef enum logic [0:0] {
    REG_SIDE   = 1'b0,
    REG_WINDOW = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [SIDE_W-1:0]   side;
    logic [WINDOW_W-1:0] window;
    logic                restart;
  } cfg_t;

  typedef struct packed {
    logic signed [BEST_W-1:0] best_sum;
    logic                     no_window;
  } result_t;

endpackage

// ----- rtl/core/msws_if.sv -----
// Valid/ready channel interfaces for sample items and result items.
// Depends on msws_pkg.
`timescale 1ns / 1ps

interface msws_in_if #(
  parameter int SAMPLE_BITS = msws_pkg::DEF_SAMPLE_BITS
);
  import msws_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface msws_out_if;
  import msws_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [BEST_W-1:0] best_sum;
  logic                     no_window;

  modport source (output valid, output best_sum, output no_window, input ready);
  modport sink   (input valid, input best_sum, input no_window, output ready);
endinterface

// ----- rtl/core/max_square_window_sum_top.sv -----
// Maximum square window sum - top level. Depends on msws_pkg, msws_if, msws_ram,
// msws_cfg and msws_out_fifo.
// Throughput: one sample item per cycle while the result queue has room; the
// column-sum and line-store RAMs are each read and written once per item
// through a four-stage pipe. A result is registered in S1, S2, S3, then queued.
// Reset (synchronous, rst_n low): side = 1024, window = 1, stream at top-left,
// best sum at its most negative value. No RAM clearing pass is run.
`timescale 1ns / 1ps

module max_square_window_sum_top #(
  parameter int MAX_SIDE    = msws_pkg::DEF_MAX_SIDE,
  parameter int MAX_WINDOW  = msws_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = msws_pkg::DEF_SAMPLE_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  msws_in_if.sink                     in_ch,
  msws_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msws_pkg::CFG_AW-1:0] paddr,
  input  logic [msws_pkg::CFG_DW-1:0] pwdata,
  output logic [msws_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import msws_pkg::*;

  // ---------------------------------------------------------------------------
  // Sizes. Line store rows sit on power-of-two strides so the slot address
  // is just {row slot, column}.
  // ---------------------------------------------------------------------------
  localparam int COL_IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int WIN_IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int HIST_AW    = WIN_IDX_W + COL_IDX_W;
  localparam int HIST_DEPTH = 2 ** HIST_AW;
  localparam int COL_W      = SAMPLE_BITS + WIN_IDX_W + 1;  // sum of window samples
  localparam int RWS_W      = COL_W + WIN_IDX_W;            // sum of window columns
  localparam int SCNT_W     = $clog2(MAX_SIDE + 1);
  localparam int WCNT_W     = $clog2(MAX_WINDOW + 1);
  localparam int PEND_W     = OCNT_W + 1;

  // S1: item taken, RAM reads in flight
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [COL_IDX_W-1:0]          col;
    logic [HIST_AW-1:0]            slot;
    logic                          first_row;
    logic                          row_ge_w;
    logic                          col_zero;
    logic                          col_ge_w;
    logic                          cand;
    logic                          last;
    logic                          nowin;
  } s1_t;

  // S2: new column sum known
  typedef struct packed {
    logic signed [COL_W-1:0] col_val;
    logic                    col_zero;
    logic                    col_ge_w;
    logic                    cand;
    logic                    last;
    logic                    nowin;
  } s2_t;

  // S3: window sum known, compare against best
  typedef struct packed {
    logic cand;
    logic last;
    logic nowin;
  } s3_t;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  cfg_t cfg;

  msws_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Out-of-range settings clamp: zero acts as one, too large as the maximum.
  logic [SCNT_W-1:0] side_eff;
  logic [WCNT_W-1:0] win_eff;

  always_comb begin
    if (cfg.side == '0) begin
      side_eff = SCNT_W'(1);
    end else if (32'(cfg.side) > MAX_SIDE) begin
      side_eff = SCNT_W'(MAX_SIDE);
    end else begin
      side_eff = SCNT_W'(cfg.side);
    end
  end

  always_comb begin
    if (cfg.window == '0) begin
      win_eff = WCNT_W'(1);
    end else if (32'(cfg.window) > MAX_WINDOW) begin
      win_eff = WCNT_W'(MAX_WINDOW);
    end else begin
      win_eff = WCNT_W'(cfg.window);
    end
  end

  // ---------------------------------------------------------------------------
  // S0: stream position and RAM read issue
  // ---------------------------------------------------------------------------
  logic [COL_IDX_W-1:0] col_r, col_nxt;
  logic [COL_IDX_W-1:0] row_r, row_nxt;
  logic [WIN_IDX_W-1:0] rmod_r, rmod_nxt;   // row modulo window = line store row
  logic                 in_acc;
  logic                 last_col, last_row;
  logic [HIST_AW-1:0]   slot;
  s1_t                  s1_in;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign last_col = (32'(col_r) + 32'd1) == 32'(side_eff);
  assign last_row = (32'(row_r) + 32'd1) == 32'(side_eff);
  assign slot     = {rmod_r, col_r};

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    rmod_nxt = rmod_r;
    if (cfg.restart) begin
      col_nxt  = '0;
      row_nxt  = '0;
      rmod_nxt = '0;
    end else if (in_acc) begin
      if (!last_col) begin
        col_nxt = col_r + COL_IDX_W'(1);
      end else if (last_row) begin
        // end of matrix: back to the top-left corner
        col_nxt  = '0;
        row_nxt  = '0;
        rmod_nxt = '0;
      end else begin
        col_nxt  = '0;
        row_nxt  = row_r + COL_IDX_W'(1);
        rmod_nxt = ((32'(rmod_r) + 32'd1) == 32'(win_eff)) ? '0
                                                            : rmod_r + WIN_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      rmod_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      rmod_r <= rmod_nxt;
    end
  end

  always_comb begin
    s1_in.sample    = in_ch.sample;
    s1_in.col       = col_r;
    s1_in.slot      = slot;
    s1_in.first_row = (row_r == '0);
    s1_in.row_ge_w  = 32'(row_r) >= 32'(win_eff);
    s1_in.col_zero  = (col_r == '0);
    s1_in.col_ge_w  = 32'(col_r) >= 32'(win_eff);
    // a full window ends here
    s1_in.cand      = ((32'(row_r) + 32'd1) >= 32'(win_eff)) &&
                      ((32'(col_r) + 32'd1) >= 32'(win_eff));
    s1_in.last      = last_col && last_row;
    s1_in.nowin     = 32'(win_eff) > 32'(side_eff);
  end

  // ---------------------------------------------------------------------------
  // S1: column sum read-modify-write and line store swap
  // The same column is only taken on consecutive cycles when the side is one,
  // and then every row is the first row, which overwrites; the line store slot
  // then recurs too, but its read data is unused. So no forwarding path exists.
  // ---------------------------------------------------------------------------
  logic                    s1_vld_r;
  s1_t                     s1_r;
  logic [COL_W-1:0]        colsum_q;
  logic [SAMPLE_BITS-1:0]  hist_q;
  logic signed [COL_W-1:0] samp_ext, hist_ext, old_col, new_col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_in;
    end
  end

  msws_ram #(
    .WIDTH (COL_W),
    .DEPTH (MAX_SIDE)
  ) u_col_ram (
    .clk   (clk),
    .we    (s1_vld_r),
    .waddr (s1_r.col),
    .wdata (new_col),
    .raddr (col_r),
    .rdata (colsum_q)
  );

  msws_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (s1_vld_r),
    .waddr (s1_r.slot),
    .wdata (s1_r.sample),
    .raddr (slot),
    .rdata (hist_q)
  );

  assign samp_ext = COL_W'(s1_r.sample);
  assign hist_ext = COL_W'($signed(hist_q));
  assign old_col  = $signed(colsum_q);

  always_comb begin
    if (s1_r.first_row) begin
      new_col = samp_ext;
    end else if (s1_r.row_ge_w) begin
      // oldest row leaves the column window
      new_col = old_col + samp_ext - hist_ext;
    end else begin
      new_col = old_col + samp_ext;
    end
  end

  // ---------------------------------------------------------------------------
  // S2: running horizontal sum over the last window column sums.
  // The column sums of the current row are kept in a short shift line; the
  // tap at window-1 is the column that drops out.
  // ---------------------------------------------------------------------------
  logic                    s2_vld_r;
  s2_t                     s2_r;
  logic signed [COL_W-1:0] line_r [MAX_WINDOW];
  logic signed [COL_W-1:0] tap;
  logic signed [RWS_W-1:0] rws_r, rws_nxt, rws_base, rws_drop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      s2_r.col_val  <= new_col;
      s2_r.col_zero <= s1_r.col_zero;
      s2_r.col_ge_w <= s1_r.col_ge_w;
      s2_r.cand     <= s1_r.cand;
      s2_r.last     <= s1_r.last;
      s2_r.nowin    <= s1_r.nowin;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      line_r[0] <= s2_r.col_val;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end
  end

  assign tap      = line_r[WIN_IDX_W'(win_eff - WCNT_W'(1))];
  assign rws_base = s2_r.col_zero ? '0 : rws_r;
  assign rws_drop = s2_r.col_ge_w ? RWS_W'(tap) : '0;
  assign rws_nxt  = rws_base + RWS_W'(s2_r.col_val) - rws_drop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rws_r <= '0;
    end else if (cfg.restart) begin
      rws_r <= '0;
    end else if (s2_vld_r) begin
      rws_r <= rws_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // S3: best-so-far compare and result emission
  // ---------------------------------------------------------------------------
  logic                     s3_vld_r;
  s3_t                      s3_r;
  logic signed [BEST_W-1:0] best_r, best_nxt, best_upd, rws_wide;
  logic                     push;
  result_t                  push_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      s3_r.cand  <= s2_r.cand;
      s3_r.last  <= s2_r.last;
      s3_r.nowin <= s2_r.nowin;
    end
  end

  assign rws_wide = BEST_W'(rws_r);
  assign best_upd = (s3_r.cand && (rws_wide > best_r)) ? rws_wide : best_r;
  assign push     = s3_vld_r && s3_r.last;

  always_comb begin
    if (s3_r.nowin) begin
      // no square fits: flag it, sum reads zero
      push_data.best_sum  = '0;
      push_data.no_window = 1'b1;
    end else begin
      push_data.best_sum  = best_upd;
      push_data.no_window = 1'b0;
    end
  end

  always_comb begin
    best_nxt = best_r;
    if (cfg.restart) begin
      best_nxt = BEST_MIN;
    end else if (s3_vld_r) begin
      best_nxt = s3_r.last ? BEST_MIN : best_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= BEST_MIN;
    end else begin
      best_r <= best_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue and input flow control. A slot is reserved for every
  // end-of-matrix item still in the pipe, so the queue never overflows and
  // the pipe itself never stalls.
  // ---------------------------------------------------------------------------
  logic [OCNT_W-1:0] fifo_cnt;
  logic [PEND_W-1:0] pend;

  msws_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .count     (fifo_cnt),
    .out_ch    (out_ch)
  );

  assign pend = PEND_W'(fifo_cnt)
              + PEND_W'(s1_vld_r && s1_r.last)
              + PEND_W'(s2_vld_r && s2_r.last)
              + PEND_W'(s3_vld_r && s3_r.last);

  assign in_ch.ready = (32'(pend) < OUT_DEPTH);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // column RAM read may only coincide with a write to the same entry on a
  // first row, where the read data is discarded
  a_col_no_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && s1_vld_r && (col_r == s1_r.col)) |-> (row_r == '0))
    else $error("column sum read overlaps pending write");

  // line store slot read never overlaps its own pending write when used
  a_hist_no_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && s1_vld_r && (slot == s1_r.slot)) |-> !s1_in.row_ge_w)
    else $error("line store read overlaps pending write");

  // credit scheme keeps the result queue from overflowing
  a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (32'(fifo_cnt) < OUT_DEPTH))
    else $error("result queue overflow");

  // a result is pushed once the last sample has moved through S1, S2 and S3
  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && s1_in.last) |=> ##1 (s2_vld_r && s2_r.last) ##1 push)
    else $error("result not produced on schedule");

endmodule

// ----- rtl/core/msws_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module msws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/msws_cfg.sv -----
// APB register block: side and window registers, restart strobe on write.
// Depends on msws_pkg.
`timescale 1ns / 1ps

module msws_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [msws_pkg::CFG_AW-1:0]  paddr,
  input  logic [msws_pkg::CFG_DW-1:0]  pwdata,
  output logic [msws_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output msws_pkg::cfg_t               cfg
);
  import msws_pkg::*;

  logic [SIDE_W-1:0]   side_r;
  logic [WINDOW_W-1:0] window_r;
  logic                wr;
  reg_idx_t            idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r   <= SIDE_RST;
      window_r <= WINDOW_RST;
    end else if (wr) begin
      case (idx)
        REG_SIDE:   side_r   <= pwdata[SIDE_W-1:0];
        REG_WINDOW: window_r <= pwdata[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_SIDE:   prdata = CFG_DW'(side_r);
      REG_WINDOW: prdata = CFG_DW'(window_r);
      default:    prdata = '0;
    endcase
  end

  assign cfg.side    = side_r;
  assign cfg.window  = window_r;
  assign cfg.restart = wr;

endmodule

// ----- rtl/core/msws_out_fifo.sv -----
// Small result queue between the compare stage and the output channel.
// Depends on msws_pkg and msws_if.
`timescale 1ns / 1ps

module msws_out_fifo #(
  parameter int DEPTH = msws_pkg::OUT_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  msws_pkg::result_t push_data,
  output logic [CNT_W-1:0]  count,
  msws_out_if.source        out_ch
);
  import msws_pkg::*;

  result_t          mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pop;

  assign pop = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  assign count            = cnt_r;
  assign out_ch.valid     = (cnt_r != '0);
  assign out_ch.best_sum  = mem_r[rd_ptr_r].best_sum;
  assign out_ch.no_window = mem_r[rd_ptr_r].no_window;

endmodule
